/* hw/rtl/ttaw_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register indexes, wrap codes and helpers for the texel address pipeline.
package ttaw_pkg;

    localparam int COORD_W      = 17;
    localparam int LEVEL_W      = 4;
    localparam int BASE_W       = 16;
    localparam int DIM_W        = 16;
    localparam int TILE_W       = 9;
    localparam int TILE_REM_W   = 8;
    localparam int WRAP_W       = 15;
    localparam int OFFSET_W     = 16;
    localparam int KEY_W        = 38;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int MODE_W       = 2;

    localparam int LEVEL_COUNT_DEF = 16;

    localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(32768);
    localparam logic [TILE_W-1:0] MAX_TILE = TILE_W'(256);

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_MODE_U = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_MODE_V = 3'd5;

    typedef enum logic [MODE_W-1:0] {
        WRAP_BLACK    = 2'd0,
        WRAP_CLAMP    = 2'd1,
        WRAP_PERIODIC = 2'd2,
        WRAP_MIRROR   = 2'd3
    } wrap_mode_t;

    // Per-axis result of the non-periodic modes, plus what the modulo fix-up needs.
    typedef struct packed {
        logic [WRAP_W-1:0] pre;
        logic              outside;
        logic              periodic;
        logic              neg;
    } axis_side_t;

    function automatic logic [BASE_W-1:0] fit_base(input logic [BASE_W-1:0] v);
        logic [BASE_W-1:0] r;
        if (v == '0)
        begin
            r = BASE_W'(1);
        end
        else if (v > MAX_BASE)
        begin
            r = MAX_BASE;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [TILE_W-1:0] fit_tile(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] r;
        if (v == '0)
        begin
            r = TILE_W'(1);
        end
        else if (v > MAX_TILE)
        begin
            r = MAX_TILE;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Truncating remainder of a negative coordinate folds back to d - rem.
    function automatic logic [WRAP_W-1:0] wrap_final(input axis_side_t s,
                                                     input logic [DIM_W-1:0] dim,
                                                     input logic [DIM_W-1:0] rem);
        logic [DIM_W-1:0] flip;
        logic [WRAP_W-1:0] r;
        flip = dim - rem;
        if (!s.periodic)
        begin
            r = s.pre;
        end
        else if (s.neg && (rem != '0))
        begin
            r = flip[WRAP_W-1:0];
        end
        else
        begin
            r = rem[WRAP_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/ttaw_axis_prep.sv */
`timescale 1ns / 1ps
// One axis front end: level clamp, level dimension, clamp/mirror/black handling.
module ttaw_axis_prep
    import ttaw_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] coord,
    input  logic [LEVEL_W-1:0]        level,
    input  logic [BASE_W-1:0]         base,
    input  wrap_mode_t                mode,
    output logic                      out_valid,
    output logic [LEVEL_W-1:0]        level_out,
    output logic [DIM_W-1:0]          dim,
    output logic [COORD_W-1:0]        magnitude,
    output axis_side_t                side
);

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(LEVEL_COUNT - 1);

    logic                      valid_a_reg;
    logic signed [COORD_W-1:0] coord_a_reg;
    logic [LEVEL_W-1:0]        level_a_reg;
    logic [LEVEL_W-1:0]        level_a_next;

    logic                      valid_b_reg;
    logic signed [COORD_W-1:0] coord_b_reg;
    logic [LEVEL_W-1:0]        level_b_reg;
    logic [DIM_W-1:0]          dim_b_reg;
    logic [DIM_W-1:0]          dim_b_next;
    logic [DIM_W-1:0]          shifted;

    logic                      valid_c_reg;
    logic [LEVEL_W-1:0]        level_c_reg;
    logic [DIM_W-1:0]          dim_c_reg;
    logic [COORD_W-1:0]        mag_c_reg;
    logic [COORD_W-1:0]        mag_c_next;
    axis_side_t                side_c_reg;
    axis_side_t                side_c_next;

    logic signed [COORD_W+1:0] ce;
    logic signed [COORD_W+1:0] de;
    logic signed [COORD_W+1:0] mirror_hi;
    logic                      below;
    logic                      above;
    logic [WRAP_W-1:0]         dim_last;
    logic [WRAP_W-1:0]         coord_low;

    assign level_a_next = (32'(level) >= LEVEL_COUNT) ? LEVEL_TOP : level;

    assign shifted    = fit_base(base) >> level_a_reg;
    assign dim_b_next = (shifted == '0) ? DIM_W'(1) : shifted;

    always_comb
    begin
        ce        = (COORD_W+2)'(coord_b_reg);
        de        = signed'({3'b000, dim_b_reg});
        below     = coord_b_reg[COORD_W-1];
        above     = !below && (ce >= de);
        mirror_hi = (de <<< 1) - ce - (COORD_W+2)'(1);
        dim_last  = WRAP_W'(dim_b_reg - DIM_W'(1));
        coord_low = coord_b_reg[WRAP_W-1:0];
        mag_c_next = below ? COORD_W'(-ce) : COORD_W'(ce);

        side_c_next.pre      = coord_low;
        side_c_next.outside  = 1'b0;
        side_c_next.periodic = 1'b0;
        side_c_next.neg      = below;

        unique case (mode)
            WRAP_BLACK:
            begin
                side_c_next.outside = below || above;
            end
            WRAP_CLAMP:
            begin
                if (below)
                begin
                    side_c_next.pre = '0;
                end
                else if (above)
                begin
                    side_c_next.pre = dim_last;
                end
            end
            WRAP_PERIODIC:
            begin
                side_c_next.pre      = '0;
                side_c_next.periodic = 1'b1;
            end
            WRAP_MIRROR:
            begin
                // Reflect once, then clamp what still lies outside.
                if (below)
                begin
                    side_c_next.pre = (mag_c_next >= {1'b0, dim_b_reg}) ? dim_last
                                                                          : mag_c_next[WRAP_W-1:0];
                end
                else if (above)
                begin
                    side_c_next.pre = mirror_hi[COORD_W+1] ? '0 : mirror_hi[WRAP_W-1:0];
                end
            end
            default:
            begin
                side_c_next.pre = coord_low;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        coord_a_reg <= coord;
        level_a_reg <= level_a_next;
        coord_b_reg <= coord_a_reg;
        level_b_reg <= level_a_reg;
        dim_b_reg   <= dim_b_next;
        level_c_reg <= level_b_reg;
        dim_c_reg   <= dim_b_reg;
        mag_c_reg   <= mag_c_next;
        side_c_reg  <= side_c_next;
    end

    assign out_valid = valid_c_reg;
    assign level_out = level_c_reg;
    assign dim       = dim_c_reg;
    assign magnitude = mag_c_reg;
    assign side      = side_c_reg;

endmodule

/* hw/rtl/ttaw_divpipe.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, side data rides along.
module ttaw_divpipe
#(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 16,
    parameter int SIDE_W     = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    input  logic [SIDE_W-1:0]     side,
    output logic                  out_valid,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder,
    output logic [DIVISOR_W-1:0]  divisor_out,
    output logic [SIDE_W-1:0]     side_out
);

    // dq holds the unused dividend bits on top and the quotient bits below.
    logic                  valid_reg [DIVIDEND_W];
    logic [DIVIDEND_W-1:0] dq_reg    [DIVIDEND_W];
    logic [DIVISOR_W-1:0]  rem_reg   [DIVIDEND_W];
    logic [DIVISOR_W-1:0]  dvs_reg   [DIVIDEND_W];
    logic [SIDE_W-1:0]     side_reg  [DIVIDEND_W];

    for (genvar i = 0; i < DIVIDEND_W; i++)
    begin : g_step
        logic                  valid_cur;
        logic [DIVIDEND_W-1:0] dq_cur;
        logic [DIVISOR_W-1:0]  rem_cur;
        logic [DIVISOR_W-1:0]  dvs_cur;
        logic [SIDE_W-1:0]     side_cur;
        logic [DIVISOR_W:0]    trial;
        logic [DIVISOR_W:0]    diff;
        logic                  fits;

        if (i == 0)
        begin : g_first
            assign valid_cur = in_valid;
            assign dq_cur    = dividend;
            assign rem_cur   = '0;
            assign dvs_cur   = divisor;
            assign side_cur  = side;
        end
        else
        begin : g_next
            assign valid_cur = valid_reg[i-1];
            assign dq_cur    = dq_reg[i-1];
            assign rem_cur   = rem_reg[i-1];
            assign dvs_cur   = dvs_reg[i-1];
            assign side_cur  = side_reg[i-1];
        end

        assign trial = {rem_cur, dq_cur[DIVIDEND_W-1]};
        assign diff  = trial - {1'b0, dvs_cur};
        assign fits  = trial >= {1'b0, dvs_cur};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            dq_reg[i]   <= {dq_cur[DIVIDEND_W-2:0], fits};
            dvs_reg[i]  <= dvs_cur;
            side_reg[i] <= side_cur;
        end
    end

    assign out_valid   = valid_reg[DIVIDEND_W-1];
    assign quotient    = dq_reg[DIVIDEND_W-1];
    assign remainder   = rem_reg[DIVIDEND_W-1];
    assign divisor_out = dvs_reg[DIVIDEND_W-1];
    assign side_out    = side_reg[DIVIDEND_W-1];

endmodule

/* hw/rtl/ttaw_addr_out.sv */
`timescale 1ns / 1ps
// Texel offset multiply-add, tile key packing and the result register.
module ttaw_addr_out
    import ttaw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  black,
    input  logic [LEVEL_W-1:0]    lu,
    input  logic [LEVEL_W-1:0]    lv,
    input  logic [WRAP_W-1:0]     wu,
    input  logic [WRAP_W-1:0]     wv,
    input  logic [WRAP_W-1:0]     tu,
    input  logic [WRAP_W-1:0]     tv,
    input  logic [TILE_REM_W-1:0] ru,
    input  logic [TILE_REM_W-1:0] rv,
    input  logic [TILE_W-1:0]     tile_w,
    output logic                  done,
    output logic                  outside_black,
    output logic [WRAP_W-1:0]     wrapped_u,
    output logic [WRAP_W-1:0]     wrapped_v,
    output logic [WRAP_W-1:0]     tile_index_u,
    output logic [WRAP_W-1:0]     tile_index_v,
    output logic [OFFSET_W-1:0]   texel_offset,
    output logic [KEY_W-1:0]      tile_key
);

    localparam int PROD_W = TILE_REM_W + TILE_W;

    logic                  valid_e_reg;
    logic                  black_e_reg;
    logic [LEVEL_W-1:0]    lu_e_reg;
    logic [LEVEL_W-1:0]    lv_e_reg;
    logic [WRAP_W-1:0]     wu_e_reg;
    logic [WRAP_W-1:0]     wv_e_reg;
    logic [WRAP_W-1:0]     tu_e_reg;
    logic [WRAP_W-1:0]     tv_e_reg;
    logic [TILE_REM_W-1:0] ru_e_reg;
    logic [PROD_W-1:0]     prod_e_reg;

    logic                  done_reg;
    logic                  black_reg;
    logic [WRAP_W-1:0]     wu_reg;
    logic [WRAP_W-1:0]     wv_reg;
    logic [WRAP_W-1:0]     tu_reg;
    logic [WRAP_W-1:0]     tv_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [KEY_W-1:0]      key_reg;

    logic [PROD_W-1:0]     offset_sum;
    logic [KEY_W-1:0]      key_next;

    assign offset_sum = prod_e_reg + PROD_W'(ru_e_reg);
    assign key_next   = {tv_e_reg, tu_e_reg, lv_e_reg, lu_e_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_e_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_e_reg <= in_valid;
            done_reg    <= valid_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        black_e_reg <= black;
        lu_e_reg    <= lu;
        lv_e_reg    <= lv;
        wu_e_reg    <= wu;
        wv_e_reg    <= wv;
        tu_e_reg    <= tu;
        tv_e_reg    <= tv;
        ru_e_reg    <= ru;
        prod_e_reg  <= PROD_W'(rv) * PROD_W'(tile_w);

        // Drop every address field when a black-mode axis falls outside.
        black_reg  <= black_e_reg;
        wu_reg     <= black_e_reg ? '0 : wu_e_reg;
        wv_reg     <= black_e_reg ? '0 : wv_e_reg;
        tu_reg     <= black_e_reg ? '0 : tu_e_reg;
        tv_reg     <= black_e_reg ? '0 : tv_e_reg;
        offset_reg <= black_e_reg ? '0 : offset_sum[OFFSET_W-1:0];
        key_reg    <= black_e_reg ? '0 : key_next;
    end

    assign done          = done_reg;
    assign outside_black = black_reg;
    assign wrapped_u     = wu_reg;
    assign wrapped_v     = wv_reg;
    assign tile_index_u  = tu_reg;
    assign tile_index_v  = tv_reg;
    assign texel_offset  = offset_reg;
    assign tile_key      = key_reg;

endmodule

/* hw/rtl/tiled_texel_address_wrap.sv */
`timescale 1ns / 1ps
// Top level of the tiled texel address generator with per-axis wrap handling.
//
//  channel   handshake            payload
//  --------  -------------------  -------------------------------------------------
//  request   start, busy          coord_u, coord_v, level_u, level_v
//  result    done (one-cycle)     outside_black, wrapped_u/v, tile_index_u/v,
//                                 texel_offset, tile_key
//  config    cfg_write            cfg_index, cfg_data
//
//  One request per cycle; each result passes through 3 front-end stages, 17 stages
//  of the coordinate modulo divider, 1 fix-up stage, 15 stages of the tile divider
//  and 2 stages for the offset multiply and output.
//  busy is held low: the pipeline has no stall point since the receiver takes
//  every result beat. Reset clears the valid bits and loads the register defaults.
module tiled_texel_address_wrap
    import ttaw_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [COORD_W-1:0] coord_u,
    input  logic signed [COORD_W-1:0] coord_v,
    input  logic [LEVEL_W-1:0]        level_u,
    input  logic [LEVEL_W-1:0]        level_v,
    output logic                      done,
    output logic                      outside_black,
    output logic [WRAP_W-1:0]         wrapped_u,
    output logic [WRAP_W-1:0]         wrapped_v,
    output logic [WRAP_W-1:0]         tile_index_u,
    output logic [WRAP_W-1:0]         tile_index_v,
    output logic [OFFSET_W-1:0]       texel_offset,
    output logic [KEY_W-1:0]          tile_key
);

    localparam int SIDE_AX_W  = $bits(axis_side_t);
    localparam int SIDE1_U_W  = 2 * LEVEL_W + SIDE_AX_W;
    localparam int SIDE2_U_W  = 2 * LEVEL_W + WRAP_W;
    localparam int SIDE2_V_W  = 1 + WRAP_W;

    logic [BASE_W-1:0]  base_width_reg;
    logic [BASE_W-1:0]  base_height_reg;
    logic [TILE_W-1:0]  tile_width_reg;
    logic [TILE_W-1:0]  tile_height_reg;
    wrap_mode_t         wrap_mode_u_reg;
    wrap_mode_t         wrap_mode_v_reg;

    logic [TILE_W-1:0]  tile_w_fit;
    logic [TILE_W-1:0]  tile_h_fit;

    // front end
    logic               prep_valid_u;
    logic               prep_valid_v;
    logic [LEVEL_W-1:0] prep_level_u;
    logic [LEVEL_W-1:0] prep_level_v;
    logic [DIM_W-1:0]   prep_dim_u;
    logic [DIM_W-1:0]   prep_dim_v;
    logic [COORD_W-1:0] prep_mag_u;
    logic [COORD_W-1:0] prep_mag_v;
    axis_side_t         prep_side_u;
    axis_side_t         prep_side_v;

    // modulo divider
    logic               mod_valid_u;
    logic               mod_valid_v;
    logic [DIM_W-1:0]   mod_rem_u;
    logic [DIM_W-1:0]   mod_rem_v;
    logic [DIM_W-1:0]   mod_dim_u;
    logic [DIM_W-1:0]   mod_dim_v;
    logic [SIDE1_U_W-1:0] mod_side_u_in;
    logic [SIDE1_U_W-1:0] mod_side_u_out;
    logic [SIDE_AX_W-1:0] mod_side_v_out;
    logic [LEVEL_W-1:0] mod_lu;
    logic [LEVEL_W-1:0] mod_lv;
    axis_side_t         mod_side_u;
    axis_side_t         mod_side_v;

    // wrap fix-up stage
    logic               fix_valid_reg;
    logic               fix_black_reg;
    logic [LEVEL_W-1:0] fix_lu_reg;
    logic [LEVEL_W-1:0] fix_lv_reg;
    logic [WRAP_W-1:0]  fix_wu_reg;
    logic [WRAP_W-1:0]  fix_wv_reg;

    // tile divider
    logic               tdiv_valid_u;
    logic               tdiv_valid_v;
    logic [WRAP_W-1:0]  tdiv_q_u;
    logic [WRAP_W-1:0]  tdiv_q_v;
    logic [TILE_W-1:0]  tdiv_r_u;
    logic [TILE_W-1:0]  tdiv_r_v;
    logic [TILE_W-1:0]  tdiv_tw;
    logic [SIDE2_U_W-1:0] tdiv_side_u_out;
    logic [SIDE2_V_W-1:0] tdiv_side_v_out;
    logic [LEVEL_W-1:0] tdiv_lu;
    logic [LEVEL_W-1:0] tdiv_lv;
    logic [WRAP_W-1:0]  tdiv_wu;
    logic [WRAP_W-1:0]  tdiv_wv;
    logic               tdiv_black;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_width_reg  <= BASE_W'(1);
            base_height_reg <= BASE_W'(1);
            tile_width_reg  <= TILE_W'(64);
            tile_height_reg <= TILE_W'(64);
            wrap_mode_u_reg <= WRAP_CLAMP;
            wrap_mode_v_reg <= WRAP_CLAMP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASE_WIDTH:  base_width_reg  <= cfg_data[BASE_W-1:0];
                REG_BASE_HEIGHT: base_height_reg <= cfg_data[BASE_W-1:0];
                REG_TILE_WIDTH:  tile_width_reg  <= cfg_data[TILE_W-1:0];
                REG_TILE_HEIGHT: tile_height_reg <= cfg_data[TILE_W-1:0];
                REG_WRAP_MODE_U: wrap_mode_u_reg <= wrap_mode_t'(cfg_data[MODE_W-1:0]);
                REG_WRAP_MODE_V: wrap_mode_v_reg <= wrap_mode_t'(cfg_data[MODE_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    assign tile_w_fit = fit_tile(tile_width_reg);
    assign tile_h_fit = fit_tile(tile_height_reg);

    ttaw_axis_prep #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_prep_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .coord     (coord_u),
        .level     (level_u),
        .base      (base_width_reg),
        .mode      (wrap_mode_u_reg),
        .out_valid (prep_valid_u),
        .level_out (prep_level_u),
        .dim       (prep_dim_u),
        .magnitude (prep_mag_u),
        .side      (prep_side_u)
    );

    ttaw_axis_prep #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_prep_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .coord     (coord_v),
        .level     (level_v),
        .base      (base_height_reg),
        .mode      (wrap_mode_v_reg),
        .out_valid (prep_valid_v),
        .level_out (prep_level_v),
        .dim       (prep_dim_v),
        .magnitude (prep_mag_v),
        .side      (prep_side_v)
    );

    assign mod_side_u_in = {prep_level_u, prep_level_v, prep_side_u};

    ttaw_divpipe #(
        .DIVIDEND_W (COORD_W),
        .DIVISOR_W  (DIM_W),
        .SIDE_W     (SIDE1_U_W)
    ) u_mod_u (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (prep_valid_u & prep_valid_v),
        .dividend    (prep_mag_u),
        .divisor     (prep_dim_u),
        .side        (mod_side_u_in),
        .out_valid   (mod_valid_u),
        .quotient    (),
        .remainder   (mod_rem_u),
        .divisor_out (mod_dim_u),
        .side_out    (mod_side_u_out)
    );

    ttaw_divpipe #(
        .DIVIDEND_W (COORD_W),
        .DIVISOR_W  (DIM_W),
        .SIDE_W     (SIDE_AX_W)
    ) u_mod_v (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (prep_valid_u & prep_valid_v),
        .dividend    (prep_mag_v),
        .divisor     (prep_dim_v),
        .side        (prep_side_v),
        .out_valid   (mod_valid_v),
        .quotient    (),
        .remainder   (mod_rem_v),
        .divisor_out (mod_dim_v),
        .side_out    (mod_side_v_out)
    );

    assign {mod_lu, mod_lv, mod_side_u} = mod_side_u_out;
    assign mod_side_v                   = mod_side_v_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_valid_reg <= 1'b0;
        end
        else
        begin
            fix_valid_reg <= mod_valid_u & mod_valid_v;
        end
    end

    always_ff @(posedge clk)
    begin
        fix_black_reg <= mod_side_u.outside | mod_side_v.outside;
        fix_lu_reg    <= mod_lu;
        fix_lv_reg    <= mod_lv;
        fix_wu_reg    <= wrap_final(mod_side_u, mod_dim_u, mod_rem_u);
        fix_wv_reg    <= wrap_final(mod_side_v, mod_dim_v, mod_rem_v);
    end

    ttaw_divpipe #(
        .DIVIDEND_W (WRAP_W),
        .DIVISOR_W  (TILE_W),
        .SIDE_W     (SIDE2_U_W)
    ) u_tile_u (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (fix_valid_reg),
        .dividend    (fix_wu_reg),
        .divisor     (tile_w_fit),
        .side        ({fix_lu_reg, fix_lv_reg, fix_wu_reg}),
        .out_valid   (tdiv_valid_u),
        .quotient    (tdiv_q_u),
        .remainder   (tdiv_r_u),
        .divisor_out (tdiv_tw),
        .side_out    (tdiv_side_u_out)
    );

    ttaw_divpipe #(
        .DIVIDEND_W (WRAP_W),
        .DIVISOR_W  (TILE_W),
        .SIDE_W     (SIDE2_V_W)
    ) u_tile_v (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (fix_valid_reg),
        .dividend    (fix_wv_reg),
        .divisor     (tile_h_fit),
        .side        ({fix_black_reg, fix_wv_reg}),
        .out_valid   (tdiv_valid_v),
        .quotient    (tdiv_q_v),
        .remainder   (tdiv_r_v),
        .divisor_out (),
        .side_out    (tdiv_side_v_out)
    );

    assign {tdiv_lu, tdiv_lv, tdiv_wu} = tdiv_side_u_out;
    assign {tdiv_black, tdiv_wv}       = tdiv_side_v_out;

    ttaw_addr_out u_addr_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (tdiv_valid_u & tdiv_valid_v),
        .black         (tdiv_black),
        .lu            (tdiv_lu),
        .lv            (tdiv_lv),
        .wu            (tdiv_wu),
        .wv            (tdiv_wv),
        .tu            (tdiv_q_u),
        .tv            (tdiv_q_v),
        .ru            (tdiv_r_u[TILE_REM_W-1:0]),
        .rv            (tdiv_r_v[TILE_REM_W-1:0]),
        .tile_w        (tdiv_tw),
        .done          (done),
        .outside_black (outside_black),
        .wrapped_u     (wrapped_u),
        .wrapped_v     (wrapped_v),
        .tile_index_u  (tile_index_u),
        .tile_index_v  (tile_index_v),
        .texel_offset  (texel_offset),
        .tile_key      (tile_key)
    );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the tiled texel address generator with wrap handling.
module tb;
    import ttaw_pkg::*;

    // Writes to these indexes fall outside the register list and must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                outside;
        logic [WRAP_W-1:0]   col;
        logic [WRAP_W-1:0]   row;
        logic [WRAP_W-1:0]   tcol;
        logic [WRAP_W-1:0]   trow;
        logic [OFFSET_W-1:0] offset;
        logic [KEY_W-1:0]    key;
    } texel_addr_t;

    typedef struct {
        bit                        is_write;
        logic [CFG_INDEX_W-1:0]    index;
        logic [CFG_DATA_W-1:0]     data;
        logic signed [COORD_W-1:0] cu;
        logic signed [COORD_W-1:0] cv;
        logic [LEVEL_W-1:0]        lu;
        logic [LEVEL_W-1:0]        lv;
        bit                        typed;
        texel_addr_t               want;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic signed [COORD_W-1:0] coord_u = '0;
    logic signed [COORD_W-1:0] coord_v = '0;
    logic [LEVEL_W-1:0]        level_u = '0;
    logic [LEVEL_W-1:0]        level_v = '0;
    logic                      done;
    logic                      outside_black;
    logic [WRAP_W-1:0]         wrapped_u;
    logic [WRAP_W-1:0]         wrapped_v;
    logic [WRAP_W-1:0]         tile_index_u;
    logic [WRAP_W-1:0]         tile_index_v;
    logic [OFFSET_W-1:0]       texel_offset;
    logic [KEY_W-1:0]          tile_key;

    // Beat tagged with a hand-written expectation instead of the predicted one.
    bit                        use_typed = 1'b0;
    texel_addr_t               typed_want = '0;

    // Register copy, at reset values.
    logic [BASE_W-1:0]         reg_base_w = BASE_W'(1);
    logic [BASE_W-1:0]         reg_base_h = BASE_W'(1);
    logic [TILE_W-1:0]         reg_tile_w = TILE_W'(64);
    logic [TILE_W-1:0]         reg_tile_h = TILE_W'(64);
    wrap_mode_t                reg_mode_u = WRAP_CLAMP;
    wrap_mode_t                reg_mode_v = WRAP_CLAMP;

    texel_addr_t               pending_addr[$];
    dir_row_t                  dir_rows[$];
    int                        fault_count = 0;
    bit                        idle_on = 1'b1;

    tiled_texel_address_wrap dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .coord_u       (coord_u),
        .coord_v       (coord_v),
        .level_u       (level_u),
        .level_v       (level_v),
        .done          (done),
        .outside_black (outside_black),
        .wrapped_u     (wrapped_u),
        .wrapped_v     (wrapped_v),
        .tile_index_u  (tile_index_u),
        .tile_index_v  (tile_index_v),
        .texel_offset  (texel_offset),
        .tile_key      (tile_key)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic int level_dim(input logic [BASE_W-1:0] base, input logic [LEVEL_W-1:0] lvl);
        int b;
        int l;
        int d;
        b = (base == 0) ? 1 : ((base > MAX_BASE) ? int'(MAX_BASE) : int'(base));
        l = (lvl >= LEVEL_COUNT_DEF) ? LEVEL_COUNT_DEF - 1 : int'(lvl);
        d = b >> l;
        return (d == 0) ? 1 : d;
    endfunction

    function automatic int tile_dim(input logic [TILE_W-1:0] t);
        return (t == 0) ? 1 : ((t > MAX_TILE) ? int'(MAX_TILE) : int'(t));
    endfunction

    // Returns 0 when black mode finds the coordinate outside.
    function automatic bit wrap_coord(input int c, input int d, input wrap_mode_t mode,
                                      output int r);
        r = 0;
        case (mode)
            WRAP_BLACK:
            begin
                if (c < 0 || c >= d)
                begin
                    return 1'b0;
                end
                r = c;
            end
            WRAP_CLAMP:
            begin
                r = (c < 0) ? 0 : ((c >= d) ? d - 1 : c);
            end
            WRAP_PERIODIC:
            begin
                r = c % d;
                if (r < 0)
                begin
                    r += d;
                end
            end
            default:
            begin
                // single reflection, then clamp whatever is still out of range
                if (c < 0)
                begin
                    r = -c;
                end
                else if (c >= d)
                begin
                    r = 2 * d - c - 1;
                end
                else
                begin
                    r = c;
                end
                if (r < 0)
                begin
                    r = 0;
                end
                else if (r >= d)
                begin
                    r = d - 1;
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic texel_addr_t texel_address(input logic signed [COORD_W-1:0] cu,
                                                  input logic signed [COORD_W-1:0] cv,
                                                  input logic [LEVEL_W-1:0] lu,
                                                  input logic [LEVEL_W-1:0] lv);
        int du;
        int dv;
        int tw;
        int th;
        int wu;
        int wv;
        int tu;
        int tv;
        bit ok_u;
        bit ok_v;
        texel_addr_t a;
        du = level_dim(reg_base_w, lu);
        dv = level_dim(reg_base_h, lv);
        tw = tile_dim(reg_tile_w);
        th = tile_dim(reg_tile_h);
        ok_u = wrap_coord(int'(cu), du, reg_mode_u, wu);
        ok_v = wrap_coord(int'(cv), dv, reg_mode_v, wv);
        a = '0;
        if (!ok_u || !ok_v)
        begin
            a.outside = 1'b1;
            return a;
        end
        tu = wu / tw;
        tv = wv / th;
        a.col    = WRAP_W'(wu);
        a.row    = WRAP_W'(wv);
        a.tcol   = WRAP_W'(tu);
        a.trow   = WRAP_W'(tv);
        a.offset = OFFSET_W'((wv - tv * th) * tw + (wu - tu * tw));
        // levels in the low byte, tile column from bit 8, tile row from bit 23
        a.key    = KEY_W'(lu) | (KEY_W'(lv) << 4) | (KEY_W'(tu) << 8) | (KEY_W'(tv) << 23);
        return a;
    endfunction

    function automatic texel_addr_t only_key(input logic [KEY_W-1:0] k);
        texel_addr_t a;
        a = '0;
        a.key = k;
        return a;
    endfunction

    function automatic texel_addr_t black_addr();
        texel_addr_t a;
        a = '0;
        a.outside = 1'b1;
        return a;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // Predict on each accepted request beat, check each result beat, track register writes.
    always @(posedge clk)
    begin
        texel_addr_t got;
        texel_addr_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pending_addr.push_back(use_typed ? typed_want
                                       : texel_address(coord_u, coord_v, level_u, level_v));
            end
            if (done === 1'b1)
            begin
                got = {outside_black, wrapped_u, wrapped_v, tile_index_u, tile_index_v,
                       texel_offset, tile_key};
                if (pending_addr.size() == 0)
                begin
                    note_fault("result beat with no request pending");
                end
                else
                begin
                    want = pending_addr.pop_front();
                    if (got !== want)
                    begin
                        note_fault($sformatf({"mismatch: exp out=%0b u=%0d v=%0d tu=%0d tv=%0d ",
                            "off=%0d key=%h / got out=%0b u=%0d v=%0d tu=%0d tv=%0d ",
                            "off=%0d key=%h"},
                            want.outside, want.col, want.row, want.tcol, want.trow,
                            want.offset, want.key,
                            got.outside, got.col, got.row, got.tcol, got.trow,
                            got.offset, got.key));
                    end
                end
            end
            else if (done !== 1'b0)
            begin
                note_fault("done is unknown");
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BASE_WIDTH:  reg_base_w = cfg_data[BASE_W-1:0];
                    REG_BASE_HEIGHT: reg_base_h = cfg_data[BASE_W-1:0];
                    REG_TILE_WIDTH:  reg_tile_w = cfg_data[TILE_W-1:0];
                    REG_TILE_HEIGHT: reg_tile_h = cfg_data[TILE_W-1:0];
                    REG_WRAP_MODE_U: reg_mode_u = wrap_mode_t'(cfg_data[MODE_W-1:0]);
                    REG_WRAP_MODE_V: reg_mode_v = wrap_mode_t'(cfg_data[MODE_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // Drop start and hold until every predicted address has come back.
    task automatic drain_all();
        @(negedge clk);
        start = 1'b0;
        while (pending_addr.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        drain_all();
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic send_texel(input logic signed [COORD_W-1:0] cu,
                              input logic signed [COORD_W-1:0] cv,
                              input logic [LEVEL_W-1:0] lu,
                              input logic [LEVEL_W-1:0] lv,
                              input bit typed,
                              input texel_addr_t want);
        if (idle_on)
        begin
            while ($urandom_range(99) < 26)
            begin
                @(negedge clk);
                start = 1'b0;
            end
        end
        @(negedge clk);
        start      = 1'b1;
        coord_u    = cu;
        coord_v    = cv;
        level_u    = lu;
        level_v    = lv;
        use_typed  = typed;
        typed_want = want;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
    endtask

    function automatic void dir_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        dir_rows.push_back('{1'b1, idx, d, '0, '0, '0, '0, 1'b0, '0});
    endfunction

    function automatic void dir_texel(input int cu, input int cv, input int lu, input int lv);
        dir_rows.push_back('{1'b0, '0, '0, COORD_W'(cu), COORD_W'(cv), LEVEL_W'(lu),
                             LEVEL_W'(lv), 1'b0, '0});
    endfunction

    function automatic void dir_checked(input int cu, input int cv, input int lu, input int lv,
                                        input texel_addr_t want);
        dir_rows.push_back('{1'b0, '0, '0, COORD_W'(cu), COORD_W'(cv), LEVEL_W'(lu),
                             LEVEL_W'(lv), 1'b1, want});
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_base();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(32768);
            3:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(300, 1));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_tile();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(256);
            3:       return CFG_DATA_W'($urandom);
            4:       return CFG_DATA_W'(1) << $urandom_range(8);
            default: return CFG_DATA_W'($urandom_range(64, 1));
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        return ($urandom_range(3) == 0) ? LEVEL_W'($urandom_range(15))
                                        : LEVEL_W'($urandom_range(3));
    endfunction

    // Mostly near the level's range so every wrap branch gets hit, plus edges and full range.
    function automatic logic signed [COORD_W-1:0] pick_coord(input int d);
        int c;
        case ($urandom_range(9))
            0:
            begin
                return COORD_W'($urandom);
            end
            1:
            begin
                case ($urandom_range(7))
                    0:       c = -1;
                    1:       c = 0;
                    2:       c = d - 1;
                    3:       c = d;
                    4:       c = 2 * d - 1;
                    5:       c = 2 * d;
                    6:       c = -d;
                    default: c = $urandom_range(1) ? -65536 : 65535;
                endcase
            end
            default:
            begin
                c = int'($urandom_range(6 * d)) - 3 * d;
            end
        endcase
        if (c < -65536)
        begin
            c = -65536;
        end
        else if (c > 65535)
        begin
            c = 65535;
        end
        return COORD_W'(c);
    endfunction

    initial
    begin
        logic [LEVEL_W-1:0] lu;
        logic [LEVEL_W-1:0] lv;
        logic signed [COORD_W-1:0] cu;
        logic signed [COORD_W-1:0] cv;

        // 1 x 1 texture after reset: everything clamps to texel 0, key holds the levels
        dir_checked(0, 0, 0, 0, only_key(38'h0));
        dir_checked(-65536, 65535, 15, 15, only_key(38'hFF));
        dir_checked(65535, -65536, 5, 10, only_key(38'hA5));
        // largest base, oversized height, widest tile, zero tile height, black on both axes
        dir_write(REG_BASE_WIDTH, 16'd32768);
        dir_write(REG_BASE_HEIGHT, 16'hFFFF);
        dir_write(REG_TILE_WIDTH, 16'd256);
        dir_write(REG_TILE_HEIGHT, 16'd0);
        dir_write(REG_WRAP_MODE_U, CFG_DATA_W'(WRAP_BLACK));
        dir_write(REG_WRAP_MODE_V, CFG_DATA_W'(WRAP_BLACK));
        dir_checked(-1, 0, 0, 0, black_addr());
        dir_checked(0, 32768, 0, 0, black_addr());
        dir_checked(65535, 0, 15, 0, black_addr());
        dir_checked(0, -65536, 0, 0, black_addr());
        dir_texel(32767, 32767, 0, 0);
        dir_texel(0, 0, 15, 15);
        // periodic; tile writes exceed the largest tile or carry bits above the register width
        dir_write(REG_BASE_WIDTH, 16'd100);
        dir_write(REG_BASE_HEIGHT, 16'd7);
        dir_write(REG_TILE_WIDTH, 16'h01FF);
        dir_write(REG_TILE_HEIGHT, 16'hFE0C);
        dir_write(REG_WRAP_MODE_U, CFG_DATA_W'(WRAP_PERIODIC));
        dir_write(REG_WRAP_MODE_V, CFG_DATA_W'(WRAP_PERIODIC));
        dir_texel(-1, -7, 0, 0);
        dir_texel(-100, -65536, 0, 0);
        dir_texel(65535, 13, 0, 0);
        dir_texel(200, 6, 1, 1);
        // mirror, including reflections that land out of range
        dir_write(REG_BASE_WIDTH, 16'd10);
        dir_write(REG_BASE_HEIGHT, 16'd3);
        dir_write(REG_TILE_WIDTH, 16'd4);
        dir_write(REG_TILE_HEIGHT, 16'd2);
        dir_write(REG_WRAP_MODE_U, CFG_DATA_W'(WRAP_MIRROR));
        dir_write(REG_WRAP_MODE_V, CFG_DATA_W'(WRAP_MIRROR));
        dir_texel(-1, 3, 0, 0);
        dir_texel(19, -3, 0, 0);
        dir_texel(20, 65535, 0, 0);
        dir_texel(-15, -65536, 0, 0);
        dir_texel(9, 2, 0, 0);
        // clamp against black, and writes past the register list
        dir_write(REG_WRAP_MODE_U, CFG_DATA_W'(WRAP_CLAMP));
        dir_write(REG_WRAP_MODE_V, CFG_DATA_W'(WRAP_BLACK));
        dir_write(REG_SPARE_6, 16'hFFFF);
        dir_write(REG_SPARE_7, 16'h0000);
        dir_texel(-5, 0, 0, 0);
        dir_texel(65535, 2, 0, 0);
        dir_checked(0, 3, 0, 0, black_addr());
        dir_checked(9, -1, 0, 0, black_addr());

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_write)
            begin
                write_reg(dir_rows[i].index, dir_rows[i].data);
            end
            else
            begin
                send_texel(dir_rows[i].cu, dir_rows[i].cv, dir_rows[i].lu, dir_rows[i].lv,
                           dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(REG_BASE_WIDTH, 16'd32768);
                write_reg(REG_BASE_HEIGHT, 16'd1);
                write_reg(REG_TILE_WIDTH, 16'd1);
                write_reg(REG_TILE_HEIGHT, 16'd256);
                write_reg(REG_WRAP_MODE_U, CFG_DATA_W'(WRAP_MIRROR));
                write_reg(REG_WRAP_MODE_V, CFG_DATA_W'(WRAP_PERIODIC));
            end
            else if (ph == 11)
            begin
                write_reg(REG_BASE_WIDTH, 16'hFFFF);
                write_reg(REG_BASE_HEIGHT, 16'd0);
                write_reg(REG_TILE_WIDTH, 16'h01FF);
                write_reg(REG_TILE_HEIGHT, 16'd0);
                write_reg(REG_WRAP_MODE_U, CFG_DATA_W'(WRAP_PERIODIC));
                write_reg(REG_WRAP_MODE_V, CFG_DATA_W'(WRAP_MIRROR));
            end
            else
            begin
                write_reg(REG_BASE_WIDTH, pick_base());
                write_reg(REG_BASE_HEIGHT, pick_base());
                write_reg(REG_TILE_WIDTH, pick_tile());
                write_reg(REG_TILE_HEIGHT, pick_tile());
                write_reg(REG_WRAP_MODE_U, CFG_DATA_W'($urandom_range(3)));
                write_reg(REG_WRAP_MODE_V, CFG_DATA_W'($urandom_range(3)));
            end
            // back-to-back beats through two whole phases
            idle_on = !(ph == 5 || ph == 6);
            for (int n = 0; n < 100; n++)
            begin
                if (ph == 3 && n == 50)
                begin
                    drain_all();
                end
                lu = pick_level();
                lv = pick_level();
                cu = pick_coord(level_dim(reg_base_w, lu));
                cv = pick_coord(level_dim(reg_base_h, lv));
                send_texel(cu, cv, lu, lv, 1'b0, '0);
            end
        end

        drain_all();
        repeat (45) @(posedge clk);
        if (pending_addr.size() != 0)
        begin
            note_fault("requests left without a result");
        end
        if (fault_count == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
